// ===== rtl/core/lar_pkg.sv =====
// Shared types, constants and fixed point helpers for the leaf assimilation residual unit.
// No dependencies; used by lar_div and leaf_assimilation_residual_unit.
`default_nettype none

package lar_pkg;

    localparam int FRAC_BITS = 16;

    // divider geometry: quotient bits, remainder and compare widths
    localparam int QB      = 34;
    localparam int NW      = FRAC_BITS + 34;
    localparam int CW      = 33 + QB;
    localparam int DIV_LAT = QB + 2;

    // registers from accept to result: 27 plain stages plus four divider passes
    localparam int LATENCY = 27 + 4 * DIV_LAT;

    localparam int CFG_IDX_W = 4;
    localparam int CFG_W     = 31;

    typedef logic signed [31:0] fx_t;

    localparam fx_t SMAX       = 32'sh7FFFFFFF;
    localparam fx_t SMIN       = 32'sh80000000;
    localparam fx_t FX_ONE     = 32'(1 << FRAC_BITS);
    localparam fx_t FX_QUARTER = 32'(1 << (FRAC_BITS - 2));
    localparam fx_t FX_1P4     = 32'(((14 << FRAC_BITS) + 5) / 10);
    localparam fx_t FX_1P6     = 32'(((16 << FRAC_BITS) + 5) / 10);

    localparam logic [CFG_W-1:0] RST_AMBIENT  = 31'd2621440;
    localparam logic [CFG_W-1:0] RST_PRESSURE = 31'd6640;
    localparam logic [CFG_W-1:0] RST_BOUNDARY = 31'd65536;
    localparam logic [CFG_W-1:0] RST_INTERNAL = 31'd65536;
    localparam logic [CFG_W-1:0] RST_MIN_COND = 31'd0;
    localparam logic [CFG_W-1:0] RST_SLOPE    = 31'd65536;
    localparam logic [CFG_W-1:0] RST_KC       = 31'd65536;
    localparam logic [CFG_W-1:0] RST_GAMMA    = 31'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AMBIENT  = 4'd0,
        REG_PRESSURE = 4'd1,
        REG_BOUNDARY = 4'd2,
        REG_INTERNAL = 4'd3,
        REG_MIN_COND = 4'd4,
        REG_SLOPE    = 4'd5,
        REG_KC       = 4'd6,
        REG_GAMMA    = 4'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        LIM_RUBISCO  = 2'd0,
        LIM_ELECTRON = 2'd1,
        LIM_TRIOSE   = 2'd2
    } lim_t;

    typedef struct packed {
        logic e;
        fx_t  v;
    } sat_t;

    // item payload carried down the pipeline, divider passes included
    typedef struct packed {
        fx_t                a;
        fx_t                rd;
        fx_t                vc;
        fx_t                tpv;
        fx_t                g2;
        fx_t                gg;
        fx_t                rb14;
        fx_t                qj;
        fx_t                cc;
        fx_t                x;
        fx_t                y;
        fx_t                z;
        fx_t                u;
        fx_t                w;
        fx_t                ac;
        fx_t                ap;
        fx_t                gc;
        logic signed [63:0] pa;
        logic signed [63:0] pb;
        logic signed [63:0] pc;
        lim_t               lim;
        logic               flag;
    } tag_t;

    function automatic fx_t fx_u31(input logic [CFG_W-1:0] x);
        return {1'b0, x};
    endfunction

    function automatic sat_t fx_clamp(input logic signed [33:0] x);
        sat_t r;
        if (x > 34'sd2147483647)
        begin
            r.e = 1'b1;
            r.v = SMAX;
        end
        else if (x < -34'sd2147483648)
        begin
            r.e = 1'b1;
            r.v = SMIN;
        end
        else
        begin
            r.e = 1'b0;
            r.v = x[31:0];
        end
        return r;
    endfunction

    function automatic sat_t fx_add(input fx_t a, input fx_t b);
        return fx_clamp(34'(a) + 34'(b));
    endfunction

    function automatic sat_t fx_sub(input fx_t a, input fx_t b);
        return fx_clamp(34'(a) - 34'(b));
    endfunction

    function automatic sat_t fx_from_mag(input logic neg, input logic [63:0] m);
        sat_t        r;
        logic [63:0] n;
        n   = 64'd0 - m;
        r.e = 1'b0;
        if (neg)
        begin
            if (m > 64'd2147483648)
            begin
                r.e = 1'b1;
                r.v = SMIN;
            end
            else
            begin
                r.v = n[31:0];
            end
        end
        else
        begin
            if (m > 64'd2147483647)
            begin
                r.e = 1'b1;
                r.v = SMAX;
            end
            else
            begin
                r.v = m[31:0];
            end
        end
        return r;
    endfunction

    function automatic logic signed [63:0] fx_prod(input fx_t a, input fx_t b);
        return 64'(a) * 64'(b);
    endfunction

    // round half away from zero at FRAC_BITS, then saturate
    function automatic sat_t fx_mul_fin(input logic signed [63:0] p);
        logic [63:0] m;
        m = p[63] ? 64'(-p) : 64'(p);
        m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return fx_from_mag(p[63], m);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lar_div.sv =====
// Pipelined signed fixed point divider, one quotient bit per stage, rounded and saturated.
// Depends on lar_pkg.
`default_nettype none

module lar_div (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          valid_i,
    input  wire lar_pkg::fx_t  num_i,
    input  wire lar_pkg::fx_t  den_i,
    input  wire lar_pkg::tag_t tag_i,
    output logic               valid_o,
    output lar_pkg::fx_t       quo_o,
    output logic               err_o,
    output lar_pkg::tag_t      tag_o
);

    typedef struct packed {
        logic [lar_pkg::NW-1:0] rem;
        logic [32:0]            dv;
        logic [lar_pkg::QB-1:0] q;
        logic                   zero;
        logic                   anz;
        logic                   an;
        logic                   neg;
        logic                   ovf;
        lar_pkg::tag_t          tag;
    } dst_t;

    dst_t                 st_reg [0:lar_pkg::QB];
    dst_t                 st_next [0:lar_pkg::QB];
    logic [lar_pkg::QB:0] v_reg;

    logic                 valid_reg;
    lar_pkg::fx_t         quo_reg;
    logic                 err_reg;
    lar_pkg::tag_t        tag_reg;
    lar_pkg::sat_t        fin_next;

    // entry stage: magnitudes, scaled numerator with rounding term, overflow check
    always_comb
    begin
        logic [32:0]            na;
        logic [32:0]            nb;
        logic [31:0]            ma;
        logic [31:0]            mb;
        logic [lar_pkg::NW-1:0] n;
        na = num_i[31] ? 33'(-33'(num_i)) : 33'(num_i);
        nb = den_i[31] ? 33'(-33'(den_i)) : 33'(den_i);
        ma = na[31:0];
        mb = nb[31:0];
        n  = (lar_pkg::NW'(ma) << (lar_pkg::FRAC_BITS + 1)) + lar_pkg::NW'(mb);
        st_next[0].rem  = n;
        st_next[0].dv   = {mb, 1'b0};
        st_next[0].q    = '0;
        st_next[0].zero = (den_i == '0);
        st_next[0].anz  = (num_i != '0);
        st_next[0].an   = num_i[31];
        st_next[0].neg  = num_i[31] ^ den_i[31];
        st_next[0].ovf  = lar_pkg::CW'(n) >= (lar_pkg::CW'({mb, 1'b0}) << lar_pkg::QB);
        st_next[0].tag  = tag_i;
    end

    for (genvar i = 0; i < lar_pkg::QB; i++)
    begin : g_bit
        localparam int K = lar_pkg::QB - 1 - i;
        logic [lar_pkg::CW-1:0] sh;
        logic [lar_pkg::CW-1:0] df;
        logic                   ge;

        always_comb
        begin
            sh = lar_pkg::CW'(st_reg[i].dv) << K;
            ge = lar_pkg::CW'(st_reg[i].rem) >= sh;
            df = lar_pkg::CW'(st_reg[i].rem) - sh;
            st_next[i+1]      = st_reg[i];
            st_next[i+1].q[K] = ge;
            if (ge)
            begin
                st_next[i+1].rem = df[lar_pkg::NW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            v_reg     <= {v_reg[lar_pkg::QB-1:0], valid_i};
            valid_reg <= v_reg[lar_pkg::QB];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= lar_pkg::QB; k++)
        begin
            st_reg[k] <= st_next[k];
        end
        quo_reg <= fin_next.v;
        err_reg <= fin_next.e;
        tag_reg <= st_reg[lar_pkg::QB].tag;
    end

    // zero divisor, oversized quotient, or normal saturation
    always_comb
    begin
        if (st_reg[lar_pkg::QB].zero)
        begin
            fin_next.e = 1'b1;
            if (!st_reg[lar_pkg::QB].anz)
            begin
                fin_next.v = '0;
            end
            else
            begin
                fin_next.v = st_reg[lar_pkg::QB].an ? lar_pkg::SMIN : lar_pkg::SMAX;
            end
        end
        else if (st_reg[lar_pkg::QB].ovf)
        begin
            fin_next.e = 1'b1;
            fin_next.v = st_reg[lar_pkg::QB].neg ? lar_pkg::SMIN : lar_pkg::SMAX;
        end
        else
        begin
            fin_next = lar_pkg::fx_from_mag(st_reg[lar_pkg::QB].neg,
                                            64'(st_reg[lar_pkg::QB].q));
        end
    end

    assign valid_o = valid_reg;
    assign quo_o   = quo_reg;
    assign err_o   = err_reg;
    assign tag_o   = tag_reg;

    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        valid_o |-> $past(valid_i, lar_pkg::DIV_LAT))
        else $error("divider output without matching input");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[lar_pkg::QB] && st_reg[lar_pkg::QB].zero |=> err_o)
        else $error("zero divisor did not flag");

    a_fit: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[lar_pkg::QB] && !st_reg[lar_pkg::QB].zero && !st_reg[lar_pkg::QB].ovf
        && st_reg[lar_pkg::QB].q <= lar_pkg::QB'(2147483647) |=> !err_o)
        else $error("in-range quotient flagged");

endmodule

`default_nettype wire

// ===== rtl/core/leaf_assimilation_residual_unit.sv =====
// Top level of the leaf assimilation residual unit: config registers and the main pipeline.
// Depends on lar_pkg and lar_div.
//
//  channel   signals                                         handshake
//  --------  ----------------------------------------------  ------------------------
//  item in   assimilation .. dark_respiration                start & !busy
//  result    residual, limiting_rate, range_error            done, one cycle, no stall
//  config    cfg_index, cfg_data                             cfg_valid & cfg_ready
//
// One item per cycle; busy never rises. Latency is lar_pkg::LATENCY, set by four serial
// divider passes (one quotient bit per stage) plus 27 stages of multiply, round and
// saturating add.
// Reset clears the valid bits and loads the config defaults; nothing else is cleared.
// The result side cannot stall, so the pipeline advances every cycle.
`default_nettype none

module leaf_assimilation_residual_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic signed [31:0]             assimilation,
    input  wire logic [30:0]                    carboxylation_max,
    input  wire logic [30:0]                    electron_rate,
    input  wire logic [30:0]                    triose_use,
    input  wire logic [16:0]                    triose_fraction,
    input  wire logic [30:0]                    dark_respiration,
    output logic                                done,
    output logic signed [31:0]                  residual,
    output logic [1:0]                          limiting_rate,
    output logic                                range_error,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lar_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lar_pkg::CFG_W-1:0]      cfg_data
);

    localparam int NS = 26;

    // config registers
    logic [lar_pkg::CFG_W-1:0] ca_reg, pr_reg, rb_reg, ri_reg;
    logic [lar_pkg::CFG_W-1:0] g0_reg, sl_reg, kc_reg, gm_reg;
    lar_pkg::fx_t ca, pr, rb, ri, g0, sl, kc, gm;

    logic accept;

    lar_pkg::tag_t t_reg  [0:NS];
    lar_pkg::tag_t t_next [1:NS];
    lar_pkg::tag_t src    [1:NS];
    lar_pkg::tag_t t0_next;
    logic          sv     [1:NS];
    logic [NS:0]   v_reg;

    // divider connections
    logic          d1_v, d2_v, d3_v, d4_v;
    lar_pkg::fx_t  d1_q, d2_q, d3_q, d4a_q, d4b_q, d4c_q, d4d_q;
    logic          d1_e, d2_e, d3_e, d4a_e, d4b_e, d4c_e, d4d_e;
    lar_pkg::tag_t d1_tag, d2_tag, d3_tag, d4_tag, d2_tag_in;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ca_reg <= lar_pkg::RST_AMBIENT;
            pr_reg <= lar_pkg::RST_PRESSURE;
            rb_reg <= lar_pkg::RST_BOUNDARY;
            ri_reg <= lar_pkg::RST_INTERNAL;
            g0_reg <= lar_pkg::RST_MIN_COND;
            sl_reg <= lar_pkg::RST_SLOPE;
            kc_reg <= lar_pkg::RST_KC;
            gm_reg <= lar_pkg::RST_GAMMA;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (lar_pkg::reg_idx_t'(cfg_index))
                lar_pkg::REG_AMBIENT:  ca_reg <= cfg_data;
                lar_pkg::REG_PRESSURE: pr_reg <= cfg_data;
                lar_pkg::REG_BOUNDARY: rb_reg <= cfg_data;
                lar_pkg::REG_INTERNAL: ri_reg <= cfg_data;
                lar_pkg::REG_MIN_COND: g0_reg <= cfg_data;
                lar_pkg::REG_SLOPE:    sl_reg <= cfg_data;
                lar_pkg::REG_KC:       kc_reg <= cfg_data;
                lar_pkg::REG_GAMMA:    gm_reg <= cfg_data;
                default: ;  // indexes past the list are dropped
            endcase
        end
    end

    assign ca = lar_pkg::fx_u31(ca_reg);
    assign pr = lar_pkg::fx_u31(pr_reg);
    assign rb = lar_pkg::fx_u31(rb_reg);
    assign ri = lar_pkg::fx_u31(ri_reg);
    assign g0 = lar_pkg::fx_u31(g0_reg);
    assign sl = lar_pkg::fx_u31(sl_reg);
    assign kc = lar_pkg::fx_u31(kc_reg);
    assign gm = lar_pkg::fx_u31(gm_reg);

    // stage 0: item capture; x = J, y = TPU, z = alphaT
    always_comb
    begin
        t0_next      = '0;
        t0_next.a    = assimilation;
        t0_next.vc   = lar_pkg::fx_u31(carboxylation_max);
        t0_next.x    = lar_pkg::fx_u31(electron_rate);
        t0_next.y    = lar_pkg::fx_u31(triose_use);
        t0_next.z    = {15'd0, triose_fraction};
        t0_next.rd   = lar_pkg::fx_u31(dark_respiration);
    end

    // stage sources: previous stage, or a divider output
    always_comb
    begin
        for (int k = 1; k <= NS; k++)
        begin
            src[k] = t_reg[k-1];
            sv[k]  = v_reg[k-1];
        end
        src[8]  = d2_tag;
        sv[8]   = d2_v;
        src[9]  = d3_tag;
        sv[9]   = d3_v;
        src[20] = d4_tag;
        sv[20]  = d4_v;
    end

    always_comb
    begin
        d2_tag_in      = d1_tag;
        d2_tag_in.flag = d1_tag.flag | d1_e;
    end

    always_comb
    begin
        lar_pkg::sat_t r;
        lar_pkg::sat_t r2;
        for (int k = 1; k <= NS; k++)
        begin
            t_next[k] = src[k];
        end

        // S1: start 1.4*rb, S*A, J/4; 3*TPU, 2*Gamma, 1+3*alphaT
        t_next[1].pa = lar_pkg::fx_prod(lar_pkg::FX_1P4, rb);
        t_next[1].pb = lar_pkg::fx_prod(sl, src[1].a);
        t_next[1].pc = lar_pkg::fx_prod(lar_pkg::FX_QUARTER, src[1].x);
        r = lar_pkg::fx_clamp(34'sd3 * 34'(src[1].y));
        t_next[1].tpv  = r.v;
        t_next[1].flag = t_next[1].flag | r.e;
        r = lar_pkg::fx_clamp(34'sd2 * 34'(gm));
        t_next[1].g2   = r.v;
        t_next[1].flag = t_next[1].flag | r.e;
        r  = lar_pkg::fx_clamp(34'sd3 * 34'(src[1].z));
        r2 = lar_pkg::fx_add(lar_pkg::FX_ONE, r.v);
        t_next[1].x    = r2.v;
        t_next[1].flag = t_next[1].flag | r.e | r2.e;

        // S2
        r = lar_pkg::fx_mul_fin(src[2].pa);
        t_next[2].rb14 = r.v;
        t_next[2].flag = t_next[2].flag | r.e;
        r = lar_pkg::fx_mul_fin(src[2].pb);
        t_next[2].y    = r.v;
        t_next[2].flag = t_next[2].flag | r.e;
        r = lar_pkg::fx_mul_fin(src[2].pc);
        t_next[2].qj   = r.v;
        t_next[2].flag = t_next[2].flag | r.e;
        t_next[2].pa   = lar_pkg::fx_prod(src[2].x, gm);

        // S3
        r = lar_pkg::fx_mul_fin(src[3].pa);
        t_next[3].gg   = r.v;
        t_next[3].flag = t_next[3].flag | r.e;
        t_next[3].pa   = lar_pkg::fx_prod(src[3].rb14, src[3].a);

        // S4..S7: Cb = Ca - rb14*A*p
        r = lar_pkg::fx_mul_fin(src[4].pa);
        t_next[4].x    = r.v;
        t_next[4].flag = t_next[4].flag | r.e;
        t_next[5].pa   = lar_pkg::fx_prod(src[5].x, pr);
        r = lar_pkg::fx_mul_fin(src[6].pa);
        t_next[6].x    = r.v;
        t_next[6].flag = t_next[6].flag | r.e;
        r = lar_pkg::fx_sub(ca, src[7].x);
        t_next[7].x    = r.v;
        t_next[7].flag = t_next[7].flag | r.e;

        // S8: gs = g0 + S*A/Cbm
        r = lar_pkg::fx_add(g0, d2_q);
        t_next[8].x    = r.v;
        t_next[8].flag = t_next[8].flag | r.e | d2_e;

        // S9..S17: r = rb14 + 1.6*rs + ri, Cc = Ca - r*A*p
        t_next[9].pa   = lar_pkg::fx_prod(lar_pkg::FX_1P6, d3_q);
        t_next[9].flag = t_next[9].flag | d3_e;
        r = lar_pkg::fx_mul_fin(src[10].pa);
        t_next[10].x    = r.v;
        t_next[10].flag = t_next[10].flag | r.e;
        r = lar_pkg::fx_add(src[11].rb14, src[11].x);
        t_next[11].x    = r.v;
        t_next[11].flag = t_next[11].flag | r.e;
        r = lar_pkg::fx_add(src[12].x, ri);
        t_next[12].x    = r.v;
        t_next[12].flag = t_next[12].flag | r.e;
        t_next[13].pa   = lar_pkg::fx_prod(src[13].x, src[13].a);
        r = lar_pkg::fx_mul_fin(src[14].pa);
        t_next[14].x    = r.v;
        t_next[14].flag = t_next[14].flag | r.e;
        t_next[15].pa   = lar_pkg::fx_prod(src[15].x, pr);
        r = lar_pkg::fx_mul_fin(src[16].pa);
        t_next[16].x    = r.v;
        t_next[16].flag = t_next[16].flag | r.e;
        r = lar_pkg::fx_sub(ca, src[17].x);
        t_next[17].cc   = r.v;
        t_next[17].flag = t_next[17].flag | r.e;

        // S18, S19: numerators and denominators of the three limits
        t_next[18].pa = lar_pkg::fx_prod(src[18].vc, src[18].cc);
        t_next[18].pb = lar_pkg::fx_prod(src[18].tpv, src[18].cc);
        r = lar_pkg::fx_add(src[18].cc, kc);
        t_next[18].x    = r.v;
        t_next[18].flag = t_next[18].flag | r.e;
        r = lar_pkg::fx_add(src[18].cc, src[18].g2);
        t_next[18].y    = r.v;
        t_next[18].flag = t_next[18].flag | r.e;
        r = lar_pkg::fx_add(src[18].cc, src[18].gg);
        t_next[18].z    = r.v;
        t_next[18].flag = t_next[18].flag | r.e;
        r = lar_pkg::fx_mul_fin(src[19].pa);
        t_next[19].u    = r.v;
        t_next[19].flag = t_next[19].flag | r.e;
        r = lar_pkg::fx_mul_fin(src[19].pb);
        t_next[19].w    = r.v;
        t_next[19].flag = t_next[19].flag | r.e;

        // S20, S21: Aj = (J/4) * Cc/(Cc+2Gamma), 1 - Gamma/Cc
        t_next[20].ac   = d4a_q;
        t_next[20].ap   = d4c_q;
        t_next[20].gc   = d4d_q;
        t_next[20].pa   = lar_pkg::fx_prod(src[20].qj, d4b_q);
        t_next[20].flag = t_next[20].flag | d4a_e | d4b_e | d4c_e | d4d_e;
        r = lar_pkg::fx_mul_fin(src[21].pa);
        t_next[21].y    = r.v;
        t_next[21].flag = t_next[21].flag | r.e;
        r = lar_pkg::fx_sub(lar_pkg::FX_ONE, src[21].gc);
        t_next[21].x    = r.v;
        t_next[21].flag = t_next[21].flag | r.e;

        // S22: smallest gross rate, ties to the later candidate
        if (src[22].ac < src[22].y)
        begin
            t_next[22].z   = src[22].ac;
            t_next[22].lim = lar_pkg::LIM_RUBISCO;
        end
        else
        begin
            t_next[22].z   = src[22].y;
            t_next[22].lim = lar_pkg::LIM_ELECTRON;
        end
        if (!(t_next[22].z < src[22].ap))
        begin
            t_next[22].z   = src[22].ap;
            t_next[22].lim = lar_pkg::LIM_TRIOSE;
        end

        // S23..S26: A - Ag*(1 - Gamma/Cc) + Rd
        t_next[23].pa   = lar_pkg::fx_prod(src[23].z, src[23].x);
        r = lar_pkg::fx_mul_fin(src[24].pa);
        t_next[24].y    = r.v;
        t_next[24].flag = t_next[24].flag | r.e;
        r = lar_pkg::fx_sub(src[25].a, src[25].y);
        t_next[25].y    = r.v;
        t_next[25].flag = t_next[25].flag | r.e;
        r = lar_pkg::fx_add(src[26].y, src[26].rd);
        t_next[26].x    = r.v;
        t_next[26].flag = t_next[26].flag | r.e;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg[0] <= accept;
            for (int k = 1; k <= NS; k++)
            begin
                v_reg[k] <= sv[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            t_reg[0] <= t0_next;
        end
        for (int k = 1; k <= NS; k++)
        begin
            t_reg[k] <= t_next[k];
        end
    end

    // Cbm = Cb / p
    lar_div u_div_cbm (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid_i (v_reg[7]),
        .num_i   (t_reg[7].x),
        .den_i   (pr),
        .tag_i   (t_reg[7]),
        .valid_o (d1_v),
        .quo_o   (d1_q),
        .err_o   (d1_e),
        .tag_o   (d1_tag)
    );

    // S*A / Cbm
    lar_div u_div_gs (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid_i (d1_v),
        .num_i   (d1_tag.y),
        .den_i   (d1_q),
        .tag_i   (d2_tag_in),
        .valid_o (d2_v),
        .quo_o   (d2_q),
        .err_o   (d2_e),
        .tag_o   (d2_tag)
    );

    // rs = 1 / gs
    lar_div u_div_rs (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid_i (v_reg[8]),
        .num_i   (lar_pkg::FX_ONE),
        .den_i   (t_reg[8].x),
        .tag_i   (t_reg[8]),
        .valid_o (d3_v),
        .quo_o   (d3_q),
        .err_o   (d3_e),
        .tag_o   (d3_tag)
    );

    // four parallel quotients: Ac, Cc/(Cc+2Gamma), Ap, Gamma/Cc
    lar_div u_div_ac (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid_i (v_reg[19]),
        .num_i   (t_reg[19].u),
        .den_i   (t_reg[19].x),
        .tag_i   (t_reg[19]),
        .valid_o (d4_v),
        .quo_o   (d4a_q),
        .err_o   (d4a_e),
        .tag_o   (d4_tag)
    );

    lar_div u_div_aj (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid_i (v_reg[19]),
        .num_i   (t_reg[19].cc),
        .den_i   (t_reg[19].y),
        .tag_i   (t_reg[19]),
        .valid_o (),
        .quo_o   (d4b_q),
        .err_o   (d4b_e),
        .tag_o   ()
    );

    lar_div u_div_ap (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid_i (v_reg[19]),
        .num_i   (t_reg[19].w),
        .den_i   (t_reg[19].z),
        .tag_i   (t_reg[19]),
        .valid_o (),
        .quo_o   (d4c_q),
        .err_o   (d4c_e),
        .tag_o   ()
    );

    lar_div u_div_gc (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid_i (v_reg[19]),
        .num_i   (gm),
        .den_i   (t_reg[19].cc),
        .tag_i   (t_reg[19]),
        .valid_o (),
        .quo_o   (d4d_q),
        .err_o   (d4d_e),
        .tag_o   ()
    );

    assign done          = v_reg[NS];
    assign residual      = t_reg[NS].x;
    assign limiting_rate = t_reg[NS].lim;
    assign range_error   = t_reg[NS].flag;

    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, lar_pkg::LATENCY))
        else $error("result without matching item");

    a_tail: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[22] |-> ##4 done)
        else $error("item lost after limit selection");

    a_pick: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[22] && t_reg[22].lim == lar_pkg::LIM_RUBISCO |-> t_reg[22].z == t_reg[22].ac)
        else $error("rubisco limit picked with wrong rate");

endmodule

`default_nettype wire
